// ===== sv/tdpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tdpc_pkg;

    localparam int COUNT_BITS = 32;
    localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;
    localparam int FIRST_DIVISOR = 2;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_START,
        SEQ_WAIT,
        SEQ_FINISH
    } seq_state_t;

    typedef struct packed {
        logic valid;
        logic prime;
        logic restart;
    } verdict_t;

endpackage

`default_nettype wire

// ===== sv/tdpc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tdpc_in_if #(
    parameter int VALUE_BITS = 31
) ();
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic                  restart;

    modport source (output valid, output value, output restart, input ready);
    modport sink (input valid, input value, input restart, output ready);
endinterface

interface tdpc_out_if ();
    import tdpc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  is_prime_flag;
    logic [COUNT_BITS-1:0] prime_count;

    modport source (output valid, output is_prime_flag, output prime_count, input ready);
    modport sink (input valid, input is_prime_flag, input prime_count, output ready);
endinterface

`default_nettype wire

// ===== sv/trial_division_prime_counter_unit.sv =====
// Trial-division prime counter.
//
// The item channel carries one value and a restart flag per beat; the result
// channel returns one beat per item with the prime flag and the running count
// of primes since the last restart, saturating at all ones.
// Each value is tested by dividing it by 2, 3, 4, ... until the divisor
// exceeds the quotient or a division leaves no remainder. A single restoring
// divider does every division, one quotient bit per cycle. A value v takes
// floor(sqrt(v)) trials if it is prime and its smallest factor minus one if
// it is composite; values below 2 go straight to a verdict with no trial.
// With a ready receiver, the next item beat can be taken at the same edge as
// the result beat of the item before.
// Results wait in an output register, so a new item is accepted while an
// earlier result is still stalled by the receiver; the finished verdict then
// holds until that register frees up.
// Reset clears the running count and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module trial_division_prime_counter_unit #(
    parameter int VALUE_BITS = 31
) (
    input  logic              clk,
    input  logic              rst_n,
    tdpc_in_if.sink           item,
    tdpc_out_if.source        result
);
    import tdpc_pkg::*;

    verdict_t              verdict;
    logic                  take;
    logic                  div_start;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_dividend;
    logic [VALUE_BITS-1:0] div_divisor;
    logic [VALUE_BITS-1:0] div_quotient;
    logic [VALUE_BITS-1:0] div_remainder;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  flag_reg;
    logic                  flag_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [COUNT_BITS-1:0] count_base;

    tdpc_seq #(
        .VALUE_BITS (VALUE_BITS)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (item.valid),
        .in_ready      (item.ready),
        .value         (item.value),
        .restart       (item.restart),
        .take          (take),
        .verdict       (verdict),
        .div_start     (div_start),
        .div_dividend  (div_dividend),
        .div_divisor   (div_divisor),
        .div_done      (div_done),
        .div_quotient  (div_quotient),
        .div_remainder (div_remainder)
    );

    tdpc_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    assign take = verdict.valid && (!out_valid_reg || result.ready);

    always_comb
    begin
        count_base     = verdict.restart ? '0 : count_reg;
        count_next     = count_reg;
        flag_next      = flag_reg;
        out_valid_next = out_valid_reg;
        if (take)
        begin
            flag_next      = verdict.prime;
            out_valid_next = 1'b1;
            if (verdict.prime && (count_base != COUNT_TOP))
            begin
                count_next = count_base + 1'b1;
            end
            else
            begin
                count_next = count_base;
            end
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flag_reg <= flag_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.is_prime_flag = flag_reg;
    assign result.prime_count   = count_reg;

    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        take && verdict.prime && !verdict.restart && (count_reg != COUNT_TOP)
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("running count did not advance on a prime");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take && !verdict.prime && verdict.restart |=> (count_reg == '0))
        else $error("restart with a non-prime value did not clear the count");

    a_accept_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |-> !verdict.valid && !div_done)
        else $error("item accepted while a verdict or division was pending");

endmodule

`default_nettype wire

// ===== sv/tdpc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tdpc_div #(
    parameter int VALUE_BITS = 31
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [VALUE_BITS-1:0] divisor,
    output logic                  done,
    output logic [VALUE_BITS-1:0] quotient,
    output logic [VALUE_BITS-1:0] remainder
);
    import tdpc_pkg::*;

    localparam int CNT_BITS = (VALUE_BITS > 2) ? $clog2(VALUE_BITS) : 1;

    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [CNT_BITS-1:0]   cnt_next;
    logic [VALUE_BITS-1:0] rem_reg;
    logic [VALUE_BITS-1:0] rem_next;
    logic [VALUE_BITS-1:0] quo_reg;
    logic [VALUE_BITS-1:0] quo_next;
    logic [VALUE_BITS:0]   trial;
    logic [VALUE_BITS:0]   diff;
    logic                  fits;

    // One restoring step per cycle: the quotient register starts out holding
    // the dividend and takes one quotient bit in at the bottom each step.
    assign trial = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(VALUE_BITS - 1);
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
            quo_next = {quo_reg[VALUE_BITS-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider finished without having been busy");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (divisor != '0) |-> (rem_reg < divisor))
        else $error("divider remainder not below the divisor");

endmodule

`default_nettype wire

// ===== sv/tdpc_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tdpc_seq #(
    parameter int VALUE_BITS = 31
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  restart,
    input  logic                  take,
    output tdpc_pkg::verdict_t    verdict,
    output logic                  div_start,
    output logic [VALUE_BITS-1:0] div_dividend,
    output logic [VALUE_BITS-1:0] div_divisor,
    input  logic                  div_done,
    input  logic [VALUE_BITS-1:0] div_quotient,
    input  logic [VALUE_BITS-1:0] div_remainder
);
    import tdpc_pkg::*;

    localparam logic [VALUE_BITS-1:0] FIRST_D = VALUE_BITS'(FIRST_DIVISOR);

    seq_state_t            state_reg;
    seq_state_t            state_next;
    logic [VALUE_BITS-1:0] v_reg;
    logic [VALUE_BITS-1:0] v_next;
    logic [VALUE_BITS-1:0] d_reg;
    logic [VALUE_BITS-1:0] d_next;
    logic                  prime_reg;
    logic                  prime_next;
    logic                  restart_reg;
    logic                  restart_next;

    always_comb
    begin
        state_next   = state_reg;
        v_next       = v_reg;
        d_next       = d_reg;
        prime_next   = prime_reg;
        restart_next = restart_reg;
        in_ready     = 1'b0;
        div_start    = 1'b0;
        case (state_reg)
            SEQ_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    v_next       = value;
                    d_next       = FIRST_D;
                    restart_next = restart;
                    if (value < FIRST_D)
                    begin
                        prime_next = 1'b0;
                        state_next = SEQ_FINISH;
                    end
                    else
                    begin
                        state_next = SEQ_START;
                    end
                end
            end
            SEQ_START:
            begin
                div_start  = 1'b1;
                state_next = SEQ_WAIT;
            end
            SEQ_WAIT:
            begin
                if (div_done)
                begin
                    // Once the divisor passes the quotient it is past the
                    // square root, so no factor is left to find.
                    if (d_reg > div_quotient)
                    begin
                        prime_next = 1'b1;
                        state_next = SEQ_FINISH;
                    end
                    else if (div_remainder == '0)
                    begin
                        prime_next = 1'b0;
                        state_next = SEQ_FINISH;
                    end
                    else
                    begin
                        d_next     = d_reg + 1'b1;
                        state_next = SEQ_START;
                    end
                end
            end
            SEQ_FINISH:
            begin
                if (take)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg       <= v_next;
        d_reg       <= d_next;
        prime_reg   <= prime_next;
        restart_reg <= restart_next;
    end

    assign div_dividend     = v_reg;
    assign div_divisor      = d_reg;
    assign verdict.valid    = (state_reg == SEQ_FINISH);
    assign verdict.prime    = prime_reg;
    assign verdict.restart  = restart_reg;

    a_divisor_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEQ_START) || (state_reg == SEQ_WAIT) |-> (d_reg >= FIRST_D))
        else $error("trial divisor fell below the first divisor");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import tdpc_pkg::*;

    localparam int VALUE_BITS = 31;
    localparam int IDLE_PCT = 28;
    localparam int QUIET_FIRST = 70;
    localparam int QUIET_LAST = 100;
    localparam int HOLD_AT = 45;
    localparam int HOLD_CYCLES = 3000;
    localparam int RANDOM_ITEMS = 116;
    localparam int TAIL_CYCLES = 60;

    typedef struct {
        logic [VALUE_BITS-1:0] value;
        logic                  restart;
        bit                    drain;
    } number_item_t;

    typedef struct {
        logic                  prime;
        logic [COUNT_BITS-1:0] count;
    } expected_verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tdpc_in_if #(.VALUE_BITS(VALUE_BITS)) item_bus ();
    tdpc_out_if result_bus ();

    trial_division_prime_counter_unit #(.VALUE_BITS(VALUE_BITS)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus.sink),
        .result (result_bus.source)
    );

    number_item_t          pending_items[$];
    expected_verdict_t     expected_verdicts[$];
    logic [COUNT_BITS-1:0] prime_tally = '0;
    int                    beats_in = 0;
    int                    beats_offered = 0;
    int                    results_seen = 0;
    int                    primes_seen = 0;
    int                    restarts_seen = 0;
    int                    errors = 0;
    int                    hold_left = 0;
    bit                    hold_done = 1'b0;
    longint unsigned       cycles = 0;
    longint unsigned       cycle_limit = 64'd100000;
    longint unsigned       cycle_budget = 0;
    logic [VALUE_BITS-1:0] largest_value = '0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic bit prime_by_trial(input logic [VALUE_BITS-1:0] v,
                                          output int unsigned trials);
        longint unsigned n;
        longint unsigned d;
        n = 64'(v);
        trials = 0;
        if (n < FIRST_DIVISOR)
        begin
            return 1'b0;
        end
        for (d = FIRST_DIVISOR; d <= n / d; d++)
        begin
            trials++;
            if (n % d == 0)
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("tb_top: error at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    task automatic queue_number(input logic [VALUE_BITS-1:0] v, input logic rs,
                                input bit drain);
        number_item_t it;
        int unsigned  trials;
        void'(prime_by_trial(v, trials));
        it.value = v;
        it.restart = rs;
        it.drain = drain;
        pending_items.push_back(it);
        cycle_budget += 16 + (VALUE_BITS + 2) * (trials + 2);
    endtask

    function automatic expected_verdict_t predict_prime_count(input logic [VALUE_BITS-1:0] v,
                                                              input logic rs);
        expected_verdict_t ev;
        int unsigned       trials;
        if (rs)
        begin
            prime_tally = '0;
        end
        ev.prime = prime_by_trial(v, trials);
        if (ev.prime && prime_tally != COUNT_TOP)
        begin
            prime_tally = prime_tally + 1'b1;
        end
        ev.count = prime_tally;
        return ev;
    endfunction

    // Input monitor: every accepted beat updates the predicted count.
    always @(posedge clk)
    begin
        if (item_bus.valid && item_bus.ready)
        begin
            expected_verdicts.push_back(predict_prime_count(item_bus.value, item_bus.restart));
            if (expected_verdicts[$].prime)
            begin
                primes_seen++;
            end
            if (item_bus.restart)
            begin
                restarts_seen++;
            end
            if (item_bus.value > largest_value)
            begin
                largest_value = item_bus.value;
            end
            beats_in++;
        end
    end

    always @(posedge clk)
    begin
        expected_verdict_t ev;
        if (result_bus.valid && result_bus.ready)
        begin
            results_seen++;
            if (expected_verdicts.size() == 0)
            begin
                report_mismatch($sformatf("result beat with flag %0b count %0d not expected",
                                          result_bus.is_prime_flag, result_bus.prime_count));
            end
            else
            begin
                ev = expected_verdicts.pop_front();
                if (result_bus.is_prime_flag !== ev.prime)
                begin
                    report_mismatch($sformatf("result %0d: is_prime_flag %b, expected %b",
                                              results_seen, result_bus.is_prime_flag,
                                              ev.prime));
                end
                if (result_bus.prime_count !== ev.count)
                begin
                    report_mismatch($sformatf("result %0d: prime_count %0d, expected %0d",
                                              results_seen, result_bus.prime_count, ev.count));
                end
            end
        end
    end

    // Driver: a beat stays offered until the input monitor has counted it.
    always @(negedge clk)
    begin
        number_item_t nxt;
        if (!rst_n)
        begin
            item_bus.valid <= 1'b0;
        end
        else if (!item_bus.valid || beats_in == beats_offered)
        begin
            if (pending_items.size() == 0 ||
                (pending_items[0].drain && expected_verdicts.size() != 0) ||
                (!(beats_offered >= QUIET_FIRST && beats_offered < QUIET_LAST) &&
                 $urandom_range(99) < IDLE_PCT))
            begin
                item_bus.valid <= 1'b0;
            end
            else
            begin
                nxt = pending_items.pop_front();
                item_bus.value <= nxt.value;
                item_bus.restart <= nxt.restart;
                item_bus.valid <= 1'b1;
                beats_offered++;
            end
        end
    end

    // Receiver: random stalls, one long hold-off, and a stretch with no stalls.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            result_bus.ready <= 1'b0;
        end
        else if (!hold_done && beats_in >= HOLD_AT)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            result_bus.ready <= 1'b0;
        end
        else if (results_seen >= QUIET_FIRST && results_seen < QUIET_LAST)
        begin
            result_bus.ready <= 1'b1;
        end
        else
        begin
            result_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > cycle_limit)
        begin
            $display("tb_top: timeout after %0d cycles", cycles);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [VALUE_BITS-1:0] v;
        logic                  rs;
        int unsigned           pick;
        int unsigned           width;
        int unsigned           trials;
        item_bus.valid = 1'b0;
        item_bus.value = '0;
        item_bus.restart = 1'b0;
        result_bus.ready = 1'b0;

        queue_number(31'd0, 1'b0, 1'b0);
        queue_number(31'd1, 1'b0, 1'b0);
        queue_number(31'd2, 1'b0, 1'b0);
        queue_number(31'd3, 1'b0, 1'b0);
        queue_number(31'd4, 1'b0, 1'b0);
        queue_number(31'd5, 1'b0, 1'b0);
        queue_number(31'd9, 1'b0, 1'b0);
        queue_number(31'd25, 1'b0, 1'b0);
        queue_number(31'd49, 1'b0, 1'b0);
        queue_number(31'd2, 1'b1, 1'b0);
        queue_number(31'd0, 1'b1, 1'b0);
        queue_number(31'd7, 1'b0, 1'b0);
        queue_number(31'd1, 1'b1, 1'b0);
        queue_number(31'd97, 1'b0, 1'b0);
        queue_number(31'd121, 1'b0, 1'b0);
        queue_number(31'd7919, 1'b0, 1'b0);
        queue_number(31'd65521, 1'b0, 1'b0);
        queue_number(31'd65535, 1'b0, 1'b0);
        queue_number(31'd16777213, 1'b0, 1'b0);
        queue_number(31'h7FFF_FFFE, 1'b0, 1'b0);
        queue_number(31'h7FFF_FFFD, 1'b0, 1'b0);
        queue_number(31'h4000_0000, 1'b1, 1'b0);
        queue_number(31'h5555_5555, 1'b0, 1'b0);
        queue_number(31'h2AAA_AAAA, 1'b0, 1'b0);

        // Most numbers are short so that primes show up often and finish quickly.
        // Wide numbers are kept only when a small divisor ends their test early.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            rs = ($urandom_range(99) < 12);
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                width = $urandom_range(12, 1);
                v = VALUE_BITS'($urandom & ((32'd1 << width) - 1));
            end
            else if (pick < 90)
            begin
                width = $urandom_range(18, 13);
                v = VALUE_BITS'($urandom & ((32'd1 << width) - 1));
            end
            else
            begin
                do
                begin
                    v = VALUE_BITS'($urandom);
                end
                while (v < 2 || prime_by_trial(v, trials) || trials > 2000);
            end
            queue_number(v, rs, (i == 0 || i == 90));
        end
        cycle_limit = 4 * (cycle_budget + 2 * HOLD_CYCLES) + 20000;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_items.size() != 0 || beats_in != beats_offered ||
               expected_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_verdicts.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_verdicts.size()));
        end

        $display("tb_top: %0d numbers tested, %0d primes, %0d restarts, largest %0d.",
                 beats_in, primes_seen, restarts_seen, largest_value);
        $display("tb_top: one long result hold-off, two drains, %0d cycles, %0d errors.",
                 cycles, errors);
        if (errors == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
